>>> hdl/rcur_pkg.sv
// Shared constants, register indexes and types for the yaw-rate curvature estimator.
// No dependencies; every other file of the block imports this package.
package rcur_pkg;

    // Field widths
    localparam int SPEED_W   = 16;
    localparam int YAW_W     = 16;
    localparam int CURV_W    = 16;
    localparam int BMODE_W   = 8;
    localparam int TASK_W    = 3;
    localparam int THR_W     = 15;
    localparam int LIM_W     = 15;
    localparam int ALPHA_W   = 9;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_SKID_STEER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THR    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CURV_LIM   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 8'd3;

    // Register reset values
    localparam logic               SKID_RST  = 1'b1;
    localparam logic [THR_W-1:0]   THR_RST   = 15'd77;
    localparam logic [LIM_W-1:0]   LIM_RST   = 15'd22938;
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 9'd51;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

    // Mode codes
    localparam logic [BMODE_W-1:0] BMODE_DRIVE  = 8'd1;
    localparam logic [BMODE_W-1:0] BMODE_REMOTE = 8'd11;
    localparam logic [TASK_W-1:0]  TASK_NO_EST  = 3'd3;

    // pi in Q29, and 90 * 8192 = 45 << 14 for the deg/s to rad/s scaling
    localparam int PI_W = 31;
    localparam logic [PI_W-1:0] PI_Q29 = 31'd1686629713;
    localparam int K45_W = 6;
    localparam logic [K45_W-1:0] K45 = 6'd45;

    // Divider sizing: quotient bits, dividend and divisor widths
    localparam int Q_W   = 16;
    localparam int DVD_W = 48;
    localparam int DVS_W = 38;
    localparam int CNT_W = 5;

    // Divider status toward the sequencer
    typedef struct packed {
        logic done;
        logic ovf;
    } rcur_div_stat_t;

endpackage

>>> hdl/rcur_in_if.sv
// Input channel: one measurement beat per control cycle.
// Depends on rcur_pkg for field widths.
interface rcur_in_if;
    import rcur_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] left_speed;
    logic                      left_valid;
    logic signed [SPEED_W-1:0] right_speed;
    logic                      right_valid;
    logic signed [YAW_W-1:0]   yaw_rate;
    logic [BMODE_W-1:0]        drive_mode;
    logic [TASK_W-1:0]         avoid_mode;
    logic signed [CURV_W-1:0]  commanded_curvature;

    modport source (
        output valid, left_speed, left_valid, right_speed, right_valid, yaw_rate,
               drive_mode, avoid_mode, commanded_curvature,
        input  ready
    );
    modport sink (
        input  valid, left_speed, left_valid, right_speed, right_valid, yaw_rate,
               drive_mode, avoid_mode, commanded_curvature,
        output ready
    );
endinterface

>>> hdl/rcur_out_if.sv
// Output channel: one curvature result beat per input beat.
// Depends on rcur_pkg for field widths.
interface rcur_out_if;
    import rcur_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [CURV_W-1:0] steer_curvature;
    logic                     estimated;
    logic                     low_speed;

    modport source (
        output valid, steer_curvature, estimated, low_speed,
        input  ready
    );
    modport sink (
        input  valid, steer_curvature, estimated, low_speed,
        output ready
    );
endinterface

>>> hdl/rcur_cfg_if.sv
// Configuration write channel: register index plus write data.
// Depends on rcur_pkg for index and data widths.
interface rcur_cfg_if;
    import rcur_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> hdl/yaw_rate_curvature_estimator.sv
// Yaw-rate curvature estimator: passthrough or yaw/speed estimate with a low-pass filter.
// Estimate path: prep and load states, 17 divider steps, then clamp, filter and output.
// Passthrough and low-speed beats skip the divider and go from prep straight to output.
// One beat in flight (taken in idle). Reset: registers to defaults, filter state to zero.
// Depends on rcur_pkg, rcur_in_if, rcur_out_if, rcur_cfg_if and rcur_div.
module yaw_rate_curvature_estimator (
    input  logic       clk,
    input  logic       rst_n,
    rcur_in_if.sink    sample,
    rcur_out_if.source result,
    rcur_cfg_if.sink   cfg
);
    import rcur_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_CLAMP = 3'd4;
    localparam logic [2:0] S_FILT  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam int S_W    = SPEED_W + 1;
    localparam int NUM_W  = YAW_W + PI_W;
    localparam int D45_W  = S_W + K45_W;
    localparam int RAW_W  = Q_W + 2;
    localparam int PROD_W = RAW_W + ALPHA_W + 1;

    // Configuration registers
    logic               skid_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [LIM_W-1:0]   lim_reg;
    logic [ALPHA_W-1:0] alpha_reg;

    logic [2:0]               state_reg, state_next;
    logic signed [CURV_W-1:0] filt_reg, filt_next;

    // Latched beat
    logic signed [S_W-1:0]    s_reg;
    logic signed [YAW_W-1:0]  yaw_reg;
    logic signed [CURV_W-1:0] cmd_reg;
    logic                     pass_reg;

    // Datapath registers
    logic [NUM_W-1:0]         num_reg;
    logic [D45_W-1:0]         d45_reg;
    logic                     neg_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [CURV_W-1:0] res_reg, res_next;
    logic                     est_reg, est_next;
    logic                     low_reg, low_next;

    // Output register
    logic                     oval_reg;
    logic signed [CURV_W-1:0] otgt_reg;
    logic                     oest_reg;
    logic                     olow_reg;

    logic                     in_acc;
    logic signed [S_W-1:0]    vl, vr;
    logic                     mode_on;
    logic [S_W-1:0]           abs_s;
    logic [YAW_W-1:0]         abs_y;
    logic                     slow;
    logic                     div_start;
    logic [DVD_W-1:0]         div_n;
    logic [DVS_W-1:0]         div_d;
    logic [Q_W-1:0]           div_q;
    rcur_div_stat_t           div_stat;
    logic [Q_W-1:0]           lim_ext;
    logic [Q_W-1:0]           q_clip;
    logic signed [RAW_W-1:0]  raw;
    logic signed [RAW_W-1:0]  diff;
    logic [ALPHA_W-1:0]       alpha_sat;
    logic signed [PROD_W-1:0] prod_rnd;
    logic                     out_free;

    assign sample.ready = (state_reg == S_IDLE);
    assign in_acc       = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;
    assign out_free     = !oval_reg || result.ready;

    // Sum of the valid wheel speeds and the estimation enable
    assign vl = sample.left_valid  ? S_W'(sample.left_speed)  : '0;
    assign vr = sample.right_valid ? S_W'(sample.right_speed) : '0;
    assign mode_on = (sample.drive_mode == BMODE_DRIVE ||
                      sample.drive_mode == BMODE_REMOTE) &&
                     (sample.avoid_mode != TASK_NO_EST) && skid_reg;

    // Magnitudes and the low-speed test
    assign abs_s = s_reg[S_W-1] ? S_W'(-s_reg) : S_W'(s_reg);
    assign abs_y = yaw_reg[YAW_W-1] ? YAW_W'(-yaw_reg) : YAW_W'(yaw_reg);
    assign slow  = abs_s <= {1'b0, thr_reg, 1'b0};

    // Rounded division: (2*num + den) / (2*den), den = 45*|s| << 14
    assign div_start = (state_reg == S_LOAD);
    assign div_n = DVD_W'({num_reg, 1'b0}) + (DVD_W'(d45_reg) << 14);
    assign div_d = DVS_W'(d45_reg) << 15;

    rcur_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .quotient (div_q),
        .stat     (div_stat)
    );

    // Clamp, sign and filter difference
    assign lim_ext   = {1'b0, lim_reg};
    assign q_clip    = (div_stat.ovf || div_q > lim_ext) ? lim_ext : div_q;
    assign raw       = neg_reg ? -$signed({2'b00, q_clip}) : $signed({2'b00, q_clip});
    assign diff      = raw - RAW_W'(filt_reg);
    assign alpha_sat = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign prod_rnd  = prod_reg + PROD_W'(128);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        filt_next  = filt_reg;
        res_next   = res_reg;
        est_next   = est_reg;
        low_next   = low_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (pass_reg)
                begin
                    res_next   = cmd_reg;
                    est_next   = 1'b0;
                    low_next   = 1'b0;
                    state_next = S_OUT;
                end
                else if (slow)
                begin
                    res_next   = '0;
                    est_next   = 1'b1;
                    low_next   = 1'b1;
                    filt_next  = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_CLAMP;
                end
            end
            S_CLAMP:
            begin
                state_next = S_FILT;
            end
            S_FILT:
            begin
                filt_next  = filt_reg + prod_rnd[CURV_W+7:8];
                res_next   = filt_reg + prod_rnd[CURV_W+7:8];
                est_next   = 1'b1;
                low_next   = 1'b0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, configuration and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            filt_reg  <= '0;
            oval_reg  <= 1'b0;
            skid_reg  <= SKID_RST;
            thr_reg   <= THR_RST;
            lim_reg   <= LIM_RST;
            alpha_reg <= ALPHA_RST;
        end
        else
        begin
            state_reg <= state_next;
            filt_reg  <= filt_next;
            if (state_reg == S_OUT && out_free)
            begin
                oval_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                oval_reg <= 1'b0;
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_SKID_STEER: skid_reg  <= cfg.data[0];
                    REG_LOW_THR:    thr_reg   <= cfg.data[THR_W-1:0];
                    REG_CURV_LIM:   lim_reg   <= cfg.data[LIM_W-1:0];
                    REG_ALPHA:      alpha_reg <= cfg.data[ALPHA_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // Datapath: latch the beat, multiply, hold results
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s_reg    <= vl + vr;
            yaw_reg  <= sample.yaw_rate;
            cmd_reg  <= sample.commanded_curvature;
            pass_reg <= !mode_on;
        end
        if (state_reg == S_PREP)
        begin
            num_reg <= NUM_W'(abs_y) * NUM_W'(PI_Q29);
            d45_reg <= D45_W'(abs_s) * D45_W'(K45);
            neg_reg <= yaw_reg[YAW_W-1] != s_reg[S_W-1];
        end
        if (state_reg == S_CLAMP)
        begin
            prod_reg <= PROD_W'(diff) * PROD_W'($signed({1'b0, alpha_sat}));
        end
        res_reg <= res_next;
        est_reg <= est_next;
        low_reg <= low_next;
        if (state_reg == S_OUT && out_free)
        begin
            otgt_reg <= res_reg;
            oest_reg <= est_reg;
            olow_reg <= low_reg;
        end
    end

    assign result.valid           = oval_reg;
    assign result.steer_curvature = otgt_reg;
    assign result.estimated       = oest_reg;
    assign result.low_speed       = olow_reg;

endmodule

>>> hdl/rcur_div.sv
// Restoring divider, one quotient bit per cycle, with an overflow check step.
// Depends on rcur_pkg for widths and the status struct.
module rcur_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [rcur_pkg::DVD_W-1:0] dividend,
    input  logic [rcur_pkg::DVS_W-1:0] divisor,
    output logic [rcur_pkg::Q_W-1:0]   quotient,
    output rcur_pkg::rcur_div_stat_t   stat
);
    import rcur_pkg::*;

    localparam int SH_W = DVS_W + Q_W;

    logic [DVD_W-1:0] rem_reg, rem_next;
    logic [SH_W-1:0]  dsh_reg, dsh_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             ovf_reg, ovf_next;
    logic             done_reg, done_next;
    logic             ge;

    // Compare the remainder against the shifted divisor
    assign ge = {{(SH_W-DVD_W){1'b0}}, rem_reg} >= dsh_reg;

    // Step the division
    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        ovf_next  = ovf_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend;
            dsh_next  = {divisor, {Q_W{1'b0}}};
            q_next    = '0;
            cnt_next  = CNT_W'(Q_W);
            busy_next = 1'b1;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_next = rem_reg - dsh_reg[DVD_W-1:0];
            end
            if (cnt_reg == CNT_W'(Q_W))
            begin
                ovf_next = ge;
            end
            else
            begin
                q_next = {q_reg[Q_W-2:0], ge};
            end
            dsh_next = dsh_reg >> 1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // Hold control state under reset; datapath needs none
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign quotient  = q_reg;
    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;

endmodule
